// ----- hdl/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
   localparam int HEAP_BYTES_DEF   = 65536;
   localparam int HEADER_BYTES_DEF = 16;
   localparam logic [12:0] PAGE_RESET = 13'd4096;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [15:0] request_bytes;
      logic [15:0] release_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] block_address;
      logic [16:0] heap_end_now;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_REL, S_RD, S_WAIT, S_EVAL, S_DIV, S_GROW, S_WUSED, S_WREM
   } state_type;
endpackage

// ----- hdl/ffha_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- hdl/first_fit_heap_allocator_core.sv -----
// Top level of the first-fit heap allocator.
// Depends on ffha_pkg and ffha_ram.
//
// Usage: pulse start with req when busy is low; the command is transferred
// at that edge. Allocate (cmd 0) walks the block headers from address 0,
// first fit, merging runs of free blocks, growing the heap end by pages of
// the page size when the tail run is short, then splits the chosen block.
// Release (cmd 1) clears the used mark at the given header address.
// Exactly one result per command appears on rsp for one cycle with
// rsp_strobe high; the receiver cannot stall it.
// Timing: a release reads the header and then writes it back. An allocate
// reads and evaluates each block header visited on the single header RAM
// port and closes the walk; when the heap must grow it runs an 18-step
// bit-serial page division, finishes and grows the heap; it then writes
// one or two headers, and the result is registered after the last step.
// One command is in work at a time.
// Reset: heap end returns to 0 (empty heap), page size to 4096. The header
// RAM is not cleared; the walk reads only headers that were written.
// Configuration: csr_wr_en writes page size; write only while idle.
module first_fit_heap_allocator_core #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req,
   output logic              rsp_strobe,
   output ffha_pkg::rsp_type rsp,
   input  logic              csr_wr_en,
   input  logic [12:0]       csr_wr_data
);
   localparam int AW = $clog2(HEAP_BYTES);
   localparam int VW = AW + 2;   // wide enough for sums past the heap
   localparam logic [VW-1:0] HDR = VW'(HEADER_BYTES);
   localparam logic [VW-1:0] CAP = VW'(HEAP_BYTES);

   ffha_pkg::state_type state_ff, state_in;
   logic [12:0]   page_ff;
   logic [VW-1:0] heap_end_ff, heap_end_in;
   logic [VW-1:0] need_ff, need_in, upart_ff, upart_in;
   logic [VW-1:0] walk_ff, walk_in, run_ff, run_in, pos_ff, pos_in;
   logic          have_ff, have_in;
   logic [15:0]   rel_ff, rel_in;
   // division of (need - run) by page, restoring, one bit a cycle
   logic [VW-1:0] quo_ff, quo_in, rem_ff, rem_in, dvd_ff, dvd_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          rsp_strobe_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [17:0]   ram_wd, ram_rd;
   logic [16:0]   sz;
   logic          used;
   logic [VW-1:0] page_w, space, rem_sh;

   assign sz     = ram_rd[17:1];
   assign used   = ram_rd[0];
   assign page_w = (page_ff == 13'd0) ? VW'(1) : VW'(page_ff);
   assign space  = VW'(page_w * (quo_ff + VW'(1)));
   assign rem_sh = {rem_ff[VW-2:0], dvd_ff[VW-1]};

   ffha_ram #(.WIDTH(18), .DEPTH(HEAP_BYTES)) u_hdr (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ffha_pkg::S_IDLE;
         page_ff     <= ffha_pkg::PAGE_RESET;
         heap_end_ff <= '0;
         rsp_strobe  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         heap_end_ff <= heap_end_in;
         rsp_strobe  <= rsp_strobe_in;
         if (csr_wr_en) begin
            page_ff <= csr_wr_data;
         end
      end
      need_ff <= need_in;  upart_ff <= upart_in;
      walk_ff <= walk_in;  run_ff   <= run_in;
      pos_ff  <= pos_in;   have_ff  <= have_in;
      rel_ff  <= rel_in;   quo_ff   <= quo_in;
      rem_ff  <= rem_in;   dvd_ff   <= dvd_in;
      cnt_ff  <= cnt_in;   rsp_ff   <= rsp_in;
   end

   assign rsp  = rsp_ff;
   assign busy = (state_ff != ffha_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;     heap_end_in = heap_end_ff;
      need_in = need_ff;       upart_in = upart_ff;
      walk_in = walk_ff;       run_in = run_ff;
      pos_in = pos_ff;         have_in = have_ff;
      rel_in = rel_ff;         quo_in = quo_ff;
      rem_in = rem_ff;         dvd_in = dvd_ff;
      cnt_in = cnt_ff;         rsp_in = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we = 1'b0;  ram_addr = walk_ff[AW-1:0];  ram_wd = '0;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (start) begin
               need_in  = VW'(req.request_bytes) + (HDR << 1);
               upart_in = VW'(req.request_bytes) + HDR;
               rel_in   = req.release_address;
               walk_in  = '0;  run_in = '0;  have_in = 1'b0;
               state_in = (req.cmd == ffha_pkg::CMD_RELEASE) ?
                          ffha_pkg::S_REL : ffha_pkg::S_RD;
            end
         end
         ffha_pkg::S_REL: begin
            // read the header, then clear its used mark
            ram_addr = AW'(rel_ff);
            state_in = ffha_pkg::S_WAIT;
            have_in  = 1'b1;
            run_in   = '1;   // marks release path
         end
         ffha_pkg::S_RD: begin
            // hold the walk: header address on the RAM port; end it at the heap end or once the run covers the need
            if (walk_ff < heap_end_ff && run_ff < need_ff) begin
               state_in = ffha_pkg::S_WAIT;
               run_in   = run_ff;
            end else begin
               state_in = ffha_pkg::S_EVAL;
            end
         end
         ffha_pkg::S_WAIT: begin
            ram_addr = (run_ff == '1) ? AW'(rel_ff) : walk_ff[AW-1:0];
            if (run_ff == '1) begin
               if (VW'(rel_ff) < CAP) begin
                  ram_we = 1'b1;
                  ram_wd = {sz, 1'b0};
               end
               rsp_in = '{ffha_pkg::ST_DONE, 16'd0, heap_end_ff[16:0]};
               rsp_strobe_in = 1'b1;
               state_in = ffha_pkg::S_IDLE;
            end else if (sz == 17'd0) begin
               rsp_in = '{ffha_pkg::ST_CORRUPT, 16'd0, heap_end_ff[16:0]};
               rsp_strobe_in = 1'b1;
               state_in = ffha_pkg::S_IDLE;
            end else begin
               if (!used) begin
                  if (!have_ff) begin
                     have_in = 1'b1;
                     pos_in  = walk_ff;
                  end
                  run_in = run_ff + VW'(sz);
               end else begin
                  have_in = 1'b0;
                  run_in  = '0;
               end
               walk_in  = walk_ff + VW'(sz);
               state_in = ffha_pkg::S_RD;
            end
         end
         ffha_pkg::S_EVAL: begin
            if (!have_ff) begin
               pos_in = heap_end_ff;
               run_in = '0;
            end
            if (have_ff && run_ff >= need_ff) begin
               state_in = ffha_pkg::S_WUSED;
            end else begin
               dvd_in   = have_ff ? need_ff - run_ff : need_ff;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = 5'(VW);
               state_in = ffha_pkg::S_DIV;
            end
         end
         ffha_pkg::S_DIV: begin
            if (cnt_ff == 5'd0) begin
               state_in = ffha_pkg::S_GROW;
            end else begin
               dvd_in = dvd_ff << 1;
               if (rem_sh >= page_w) begin
                  rem_in = rem_sh - page_w;
                  quo_in = {quo_ff[VW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[VW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ffha_pkg::S_GROW: begin
            if (heap_end_ff + space > CAP) begin
               // keep the tail merge, drop the growth
               if (have_ff) begin
                  ram_we   = 1'b1;
                  ram_addr = pos_ff[AW-1:0];
                  ram_wd   = {run_ff[16:0], 1'b0};
               end
               rsp_in = '{ffha_pkg::ST_FULL, 16'd0, heap_end_ff[16:0]};
               rsp_strobe_in = 1'b1;
               state_in = ffha_pkg::S_IDLE;
            end else begin
               run_in      = run_ff + space;
               heap_end_in = heap_end_ff + space;
               state_in    = ffha_pkg::S_WUSED;
            end
         end
         ffha_pkg::S_WUSED: begin
            ram_we   = 1'b1;
            ram_addr = pos_ff[AW-1:0];
            ram_wd   = {upart_ff[16:0], 1'b1};
            rsp_in   = '{ffha_pkg::ST_DONE, pos_ff[15:0], heap_end_ff[16:0]};
            if (run_ff != upart_ff && pos_ff + upart_ff < CAP) begin
               state_in = ffha_pkg::S_WREM;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in = ffha_pkg::S_IDLE;
            end
         end
         ffha_pkg::S_WREM: begin
            ram_we   = 1'b1;
            ram_addr = AW'(pos_ff + upart_ff);
            ram_wd   = {17'(run_ff - upart_ff), 1'b0};
            rsp_strobe_in = 1'b1;
            state_in = ffha_pkg::S_IDLE;
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end
endmodule
